### hdl/pfr_pkg.sv
// Shared types and constants for the page framebuffer refresh unit.
`default_nettype none

package pfr_pkg;

   // Frame geometry
   localparam int unsigned WIDTH       = 72;
   localparam int unsigned HEIGHT      = 40;
   localparam int unsigned PAGES       = 5;
   localparam int unsigned STORE_BYTES = WIDTH * PAGES;
   localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
   localparam int unsigned PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;

   // Per-page stream: three command transfers, then 0x40 and one page row
   localparam int unsigned POS_PAGE_CMD = 1;
   localparam int unsigned POS_COL_LO   = 3;
   localparam int unsigned POS_COL_HI   = 5;
   localparam int unsigned POS_DATA_CTL = 6;
   localparam int unsigned POS_DATA0    = 7;
   localparam int unsigned PAGE_SPAN    = WIDTH + POS_DATA0;
   localparam int unsigned POS_W        = $clog2(PAGE_SPAN);

   localparam int unsigned OFFSET_W     = 7;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 7'd28;

   localparam logic [7:0] CTL_COMMAND = 8'h00;
   localparam logic [7:0] CTL_DATA    = 8'h40;
   localparam logic [7:0] CMD_PAGE    = 8'hB0;
   localparam logic [7:0] CMD_COL_LO  = 8'h00;
   localparam logic [7:0] CMD_COL_HI  = 8'h10;
   localparam logic [7:0] NIBBLE_MASK = 8'h0F;

   typedef enum logic [1:0] {
      REQ_PIXEL = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_FLUSH = 2'd2,
      REQ_TICK  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_WR,
      ST_TICK
   } state_type;

   // Frame store address source
   typedef enum logic [1:0] {
      RAM_PORT,
      RAM_FLUSH,
      RAM_PIX,
      RAM_CLR
   } ram_sel_type;

   typedef struct packed {
      logic        capture;
      logic        ram_rd;
      logic        ram_wr;
      ram_sel_type ram_sel;
      logic        wr_zero;
      logic        clr_start;
      logic        clr_step;
      logic        flush_start;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic pix_in_view;
      logic clr_done;
      logic busy;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

### hdl/page_framebuffer_refresh_unit.sv
// Top level of the page framebuffer refresh unit: controller, datapath, checks.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  req     | in        | req_valid/req_stall  | type, pixel_x, pixel_y, pixel_on, link_fail
//  rsp     | out       | rsp_valid/rsp_stall  | out_byte, transfer_first/last, frame_last,
//          |           |                      | flush_aborted
//  csr     | in        | csr_valid/csr_ready  | column_offset (always ready)
//
// Flush requests and pixel writes outside the view finish in ST_IDLE; in-view pixel
// writes and every tick go on to ST_PIX_WR or ST_TICK (read then write back / read then
// load, on the single port). A tick during a flush also waits while the result register
// holds an untaken byte. A clear request is taken, then sweeps the store one byte a cycle
// in ST_CLEAR with req_stall high.
// After reset the same clearing pass runs before the first request is taken.
// Reset is synchronous, active high.
`default_nettype none

module page_framebuffer_refresh_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_type,
   input  wire logic signed [8:0]            req_pixel_x,
   input  wire logic signed [8:0]            req_pixel_y,
   input  wire logic                         req_pixel_on,
   input  wire logic                         req_link_fail,
   // result channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_transfer_first,
   output logic                              rsp_transfer_last,
   output logic                              rsp_frame_last,
   output logic                              rsp_flush_aborted,
   // column offset register
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [pfr_pkg::OFFSET_W-1:0] csr_column_offset
);

   import pfr_pkg::*;

   cmd_type   cmd;
   sts_type   sts;
   state_type state;
   logic      csr_wr;

   // Register writes must come only while idle (not enforced); the port never pushes back.
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   pfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd),
      .state     (state)
   );

   pfr_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_pixel_x        (req_pixel_x),
      .req_pixel_y        (req_pixel_y),
      .req_pixel_on       (req_pixel_on),
      .req_link_fail      (req_link_fail),
      .csr_wr             (csr_wr),
      .csr_column_offset  (csr_column_offset),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_transfer_first (rsp_transfer_first),
      .rsp_transfer_last  (rsp_transfer_last),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_flush_aborted  (rsp_flush_aborted)
   );

`ifndef ASSERT_OFF
   // The clearing pass after reset holds off requests.
   a_reset_clears : assert property (@(posedge clock)
      reset |=> (req_stall && (state == ST_CLEAR)))
      else $error("no clearing pass after reset");

   // An aborted flush carries a zero byte and no framing marks.
   a_abort_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flush_aborted) |-> ((rsp_out_byte == 8'h00)
         && !rsp_transfer_first && !rsp_transfer_last && !rsp_frame_last))
      else $error("aborted request carries stream data");

   // The last byte of a flush also closes its data transfer.
   a_frame_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_last) |-> rsp_transfer_last)
      else $error("frame end without transfer end");

   // A byte never both opens and closes a transfer.
   a_first_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_transfer_first && rsp_transfer_last))
      else $error("byte marked first and last");

   // A result is loaded only from a tick in progress.
   a_emit_tick : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (state == ST_TICK))
      else $error("result loaded outside tick");
`endif

endmodule

`default_nettype wire

### hdl/pfr_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module pfr_ram #(
   parameter int unsigned DATA_W = 8,
   parameter int unsigned DEPTH  = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [DATA_W-1:0]        wdata,
   output logic      [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hdl/pfr_ctrl.sv
// Sequencing state machine for the page framebuffer refresh unit.
`default_nettype none

module pfr_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_type,
   input  wire pfr_pkg::sts_type sts,
   output logic                  req_stall,
   output pfr_pkg::cmd_type      cmd,
   output pfr_pkg::state_type    state
);

   import pfr_pkg::*;

   state_type    state_ff;
   state_type    state_in;
   req_kind_type kind;
   logic         accept;

   assign kind   = req_kind_type'(req_type);
   assign accept = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (kind)
                  REQ_PIXEL: state_in = sts.pix_in_view ? ST_PIX_WR : ST_IDLE;
                  REQ_CLEAR: state_in = ST_CLEAR;
                  REQ_FLUSH: state_in = ST_IDLE;
                  REQ_TICK:  state_in = ST_TICK;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_PIX_WR: state_in = ST_IDLE;
         ST_TICK: begin
            if (!sts.busy || sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.ram_sel = RAM_PORT;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.ram_wr   = 1'b1;
            cmd.ram_sel  = RAM_CLR;
            cmd.wr_zero  = 1'b1;
            cmd.clr_step = 1'b1;
         end
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               unique case (kind)
                  REQ_PIXEL: begin
                     cmd.ram_rd  = sts.pix_in_view;
                     cmd.ram_sel = RAM_PORT;
                  end
                  REQ_CLEAR: cmd.clr_start   = 1'b1;
                  REQ_FLUSH: cmd.flush_start = 1'b1;
                  REQ_TICK: begin
                     cmd.ram_rd  = 1'b1;
                     cmd.ram_sel = RAM_FLUSH;
                  end
                  default: cmd.capture = 1'b1;
               endcase
            end
         end
         ST_PIX_WR: begin
            cmd.ram_wr  = 1'b1;
            cmd.ram_sel = RAM_PIX;
         end
         ST_TICK: cmd.emit = sts.busy && sts.out_free;
         default: cmd = '0;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign state     = state_ff;

endmodule

`default_nettype wire

### hdl/pfr_dp.sv
// Datapath: frame store, refresh counters, byte generation and result register.
`default_nettype none

module pfr_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pfr_pkg::cmd_type               cmd,
   output pfr_pkg::sts_type                    sts,
   input  wire logic signed [8:0]              req_pixel_x,
   input  wire logic signed [8:0]              req_pixel_y,
   input  wire logic                           req_pixel_on,
   input  wire logic                           req_link_fail,
   input  wire logic                           csr_wr,
   input  wire logic [pfr_pkg::OFFSET_W-1:0]   csr_column_offset,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [7:0]                     rsp_out_byte,
   output logic                                rsp_transfer_first,
   output logic                                rsp_transfer_last,
   output logic                                rsp_frame_last,
   output logic                                rsp_flush_aborted
);

   import pfr_pkg::*;

   localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(PAGE_SPAN - 1);
   localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGES - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

   logic [OFFSET_W-1:0] column_offset_ff;
   logic                busy_ff, busy_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [ADDR_W-1:0]   clr_addr_ff;
   logic [ADDR_W-1:0]   pix_addr_ff;
   logic [2:0]          pix_bit_ff;
   logic                pix_on_ff;
   logic                link_fail_ff;

   logic                out_valid_ff;
   logic [7:0]          out_byte_ff;
   logic                out_first_ff, out_last_ff, out_flast_ff, out_abort_ff;

   logic [7:0]          x_val, y_val;
   logic                in_view;
   logic [ADDR_W-1:0]   port_addr, flush_addr, ram_addr;
   logic [7:0]          ram_wdata, ram_rdata, bit_mask;
   logic                data_phase;
   logic [7:0]          byte_w;
   logic                first_w, last_w, flast_w;

   // Pixel address straight from the request ports
   assign x_val     = req_pixel_x[7:0];
   assign y_val     = req_pixel_y[7:0];
   assign in_view   = !req_pixel_x[8] && !req_pixel_y[8]
                      && (32'(x_val) < WIDTH) && (32'(y_val) < HEIGHT);
   assign port_addr = ADDR_W'(32'(y_val[7:3]) * WIDTH + 32'(x_val));

   assign data_phase = (32'(pos_ff) >= POS_DATA0);
   assign flush_addr = data_phase
                     ? ADDR_W'(32'(page_ff) * WIDTH + 32'(pos_ff) - POS_DATA0)
                     : '0;

   always_comb begin
      unique case (cmd.ram_sel)
         RAM_PORT:  ram_addr = port_addr;
         RAM_FLUSH: ram_addr = flush_addr;
         RAM_PIX:   ram_addr = pix_addr_ff;
         RAM_CLR:   ram_addr = clr_addr_ff;
         default:   ram_addr = clr_addr_ff;
      endcase
   end

   assign bit_mask  = 8'(1) << pix_bit_ff;
   assign ram_wdata = cmd.wr_zero ? 8'h00
                    : (pix_on_ff ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask));

   pfr_ram #(
      .DATA_W (8),
      .DEPTH  (STORE_BYTES)
   ) u_store (
      .clock (clock),
      .wr_en (cmd.ram_wr),
      .rd_en (cmd.ram_rd),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Next stream byte
   always_comb begin
      byte_w  = CTL_COMMAND;
      first_w = 1'b0;
      last_w  = 1'b0;
      flast_w = 1'b0;
      priority if (32'(pos_ff) < POS_DATA_CTL) begin
         if (!pos_ff[0]) begin
            byte_w  = CTL_COMMAND;
            first_w = 1'b1;
         end else begin
            last_w = 1'b1;
            priority if (32'(pos_ff) == POS_PAGE_CMD) begin
               byte_w = CMD_PAGE | 8'(page_ff);
            end else if (32'(pos_ff) == POS_COL_LO) begin
               byte_w = CMD_COL_LO | (8'(column_offset_ff) & NIBBLE_MASK);
            end else begin
               byte_w = CMD_COL_HI | 8'(column_offset_ff[OFFSET_W-1:4]);
            end
         end
      end else if (32'(pos_ff) == POS_DATA_CTL) begin
         byte_w  = CTL_DATA;
         first_w = 1'b1;
      end else begin
         byte_w = ram_rdata;
         if (pos_ff == LAST_POS) begin
            last_w  = 1'b1;
            flast_w = (page_ff == LAST_PAGE);
         end
      end
   end

   // Refresh counters
   always_comb begin
      busy_in = busy_ff;
      page_in = page_ff;
      pos_in  = pos_ff;
      priority if (cmd.flush_start && !busy_ff) begin
         busy_in = 1'b1;
         page_in = '0;
         pos_in  = '0;
      end else if (cmd.emit && link_fail_ff) begin
         busy_in = 1'b0;
         page_in = '0;
         pos_in  = '0;
      end else if (cmd.emit) begin
         if (pos_ff == LAST_POS) begin
            pos_in = '0;
            if (page_ff == LAST_PAGE) begin
               page_in = '0;
               busy_in = 1'b0;
            end else begin
               page_in = page_ff + 1'b1;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_offset_ff <= OFFSET_RESET;
         busy_ff          <= 1'b0;
         page_ff          <= '0;
         pos_ff           <= '0;
         clr_addr_ff      <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr) begin
            column_offset_ff <= csr_column_offset;
         end
         busy_ff <= busy_in;
         page_ff <= page_in;
         pos_ff  <= pos_in;
         if (cmd.clr_start) begin
            clr_addr_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_addr_ff <= (clr_addr_ff == LAST_ADDR) ? '0 : clr_addr_ff + 1'b1;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pix_addr_ff  <= port_addr;
         pix_bit_ff   <= y_val[2:0];
         pix_on_ff    <= req_pixel_on;
         link_fail_ff <= req_link_fail;
      end
      if (cmd.emit) begin
         out_byte_ff  <= link_fail_ff ? 8'h00 : byte_w;
         out_first_ff <= !link_fail_ff && first_w;
         out_last_ff  <= !link_fail_ff && last_w;
         out_flast_ff <= !link_fail_ff && flast_w;
         out_abort_ff <= link_fail_ff;
      end
   end

   assign sts.pix_in_view = in_view;
   assign sts.clr_done    = (clr_addr_ff == LAST_ADDR);
   assign sts.busy        = busy_ff;
   assign sts.out_free    = !out_valid_ff || !rsp_stall;

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_transfer_first = out_first_ff;
   assign rsp_transfer_last  = out_last_ff;
   assign rsp_frame_last     = out_flast_ff;
   assign rsp_flush_aborted  = out_abort_ff;

endmodule

`default_nettype wire

### verif/tb_page_framebuffer_refresh_unit.sv
// Self-checking testbench for the page framebuffer refresh unit.
`timescale 1ns / 100ps
`default_nettype none

module tb_page_framebuffer_refresh_unit;
   import pfr_pkg::*;

   // Test plan: directed pixel bounds, idle ticks, aborted refresh; full refreshes at several
   // column offsets; a clear; then a random mix of writes, clears, refreshes, broken
   // refreshes and noise. A shadow frame predicts every bus byte.

   localparam int unsigned TARGET_REQUESTS = 1650;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned CYCLE_LIMIT     = 500_000;
   localparam int unsigned MAX_REPORTS     = 10;

   // One bus byte as the block reports it
   typedef struct packed {
      logic [7:0] data;
      logic       tx_first;
      logic       tx_last;
      logic       frame_end;
      logic       aborted;
   } bus_byte_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_type = REQ_PIXEL;
   logic signed [8:0]        req_pixel_x = '0;
   logic signed [8:0]        req_pixel_y = '0;
   logic                     req_pixel_on = 1'b0;
   logic                     req_link_fail = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [7:0]               rsp_out_byte;
   logic                     rsp_transfer_first;
   logic                     rsp_transfer_last;
   logic                     rsp_frame_last;
   logic                     rsp_flush_aborted;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [OFFSET_W-1:0]      csr_column_offset = OFFSET_RESET;

   page_framebuffer_refresh_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_pixel_x        (req_pixel_x),
      .req_pixel_y        (req_pixel_y),
      .req_pixel_on       (req_pixel_on),
      .req_link_fail      (req_link_fail),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_transfer_first (rsp_transfer_first),
      .rsp_transfer_last  (rsp_transfer_last),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_flush_aborted  (rsp_flush_aborted),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_column_offset  (csr_column_offset)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Shadow of the block: frame store, refresh cursor and column offset.
   // ---------------------------------------------------------------------------
   logic [7:0]          shadow_frame [STORE_BYTES];
   bit                  refreshing = 1'b0;
   int unsigned         page_no = 0;
   int unsigned         slot = 0;           // position within one page's stream
   logic [OFFSET_W-1:0] col_offset = OFFSET_RESET;
   bus_byte_type        bus_bytes_q [$];    // bytes still owed by the block

   // run statistics
   int unsigned requests_sent = 0;
   int unsigned requests_acted = 0;
   int unsigned bytes_checked = 0;
   int unsigned frames_done = 0;
   int unsigned aborts_seen = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   bit          quiet = 1'b0;               // no idling on either side while set

   initial begin
      foreach (shadow_frame[i]) shadow_frame[i] = '0;
   end

   // Applies one accepted request to the shadow; queues the byte a tick produces.
   task automatic model_request(input req_kind_type kind, input logic signed [8:0] px,
                                input logic signed [8:0] py, input logic on,
                                input logic fail, output bit acted);
      bus_byte_type b;
      int unsigned  idx;
      int unsigned  col;
      b = '0;
      acted = 1'b0;
      case (kind)
         REQ_PIXEL: begin
            // negative or beyond the glass: dropped
            if (!px[8] && !py[8] && px[7:0] < WIDTH && py[7:0] < HEIGHT) begin
               idx = (py[7:0] >> 3) * WIDTH + px[7:0];
               shadow_frame[idx][py[2:0]] = on;
               acted = 1'b1;
            end
         end
         REQ_CLEAR: begin
            foreach (shadow_frame[i]) shadow_frame[i] = '0;
            acted = 1'b1;
         end
         REQ_FLUSH: begin
            // a refresh already running is left alone
            if (!refreshing) begin
               refreshing = 1'b1;
               page_no = 0;
               slot = 0;
               acted = 1'b1;
            end
         end
         REQ_TICK: begin
            if (refreshing) begin
               acted = 1'b1;
               if (fail) begin
                  // link failure: one zero byte flagged aborted, refresh over
                  b.aborted = 1'b1;
                  refreshing = 1'b0;
                  page_no = 0;
                  slot = 0;
                  aborts_seen++;
               end else begin
                  if (slot < POS_DATA_CTL) begin
                     // three command transfers: control byte, then command
                     if (slot % 2 == 0) begin
                        b.data = CTL_COMMAND;
                        b.tx_first = 1'b1;
                     end else begin
                        b.tx_last = 1'b1;
                        case (slot)
                           POS_PAGE_CMD: b.data = CMD_PAGE | 8'(page_no);
                           POS_COL_LO:   b.data = CMD_COL_LO | (8'(col_offset) & NIBBLE_MASK);
                           default:      b.data = CMD_COL_HI | 8'(col_offset >> 4);
                        endcase
                     end
                  end else if (slot == POS_DATA_CTL) begin
                     b.data = CTL_DATA;
                     b.tx_first = 1'b1;
                  end else begin
                     col = slot - POS_DATA0;
                     b.data = shadow_frame[page_no * WIDTH + col];
                     if (col == WIDTH - 1) begin
                        b.tx_last = 1'b1;
                        b.frame_end = (page_no == PAGES - 1);
                     end
                  end
                  slot++;
                  if (slot >= PAGE_SPAN) begin
                     slot = 0;
                     page_no++;
                     if (page_no >= PAGES) begin
                        page_no = 0;
                        refreshing = 1'b0;
                        frames_done++;
                     end
                  end
               end
               bus_bytes_q.push_back(b);
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Request driver. Called at a rising edge; returns at the accepting edge with
   // valid still high, so a back-to-back request needs only one assignment.
   // ---------------------------------------------------------------------------
   task automatic send_request(input req_kind_type kind, input logic signed [8:0] px,
                               input logic signed [8:0] py, input logic on,
                               input logic fail);
      int unsigned gap;
      bit          acted;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_pixel_x   <= px;
      req_pixel_y   <= py;
      req_pixel_on  <= on;
      req_link_fail <= fail;
      do @(posedge clock); while (!(req_valid && !req_stall));
      model_request(kind, px, py, on, fail, acted);
      requests_sent++;
      if (acted) requests_acted++;
   endtask

   // Tick with don't-care pixel fields scrambled
   task automatic send_tick(input logic fail);
      send_request(REQ_TICK, 9'($urandom), 9'($urandom), 1'($urandom), fail);
   endtask

   // Mostly on-screen coordinate, sometimes anything the field can hold
   function automatic logic signed [8:0] pick_coord(input int unsigned span);
      if ($urandom_range(0, 9) < 8) return 9'($urandom_range(0, span - 1));
      return 9'($urandom);
   endfunction

   task automatic paint_pixel();
      send_request(REQ_PIXEL, pick_coord(WIDTH), pick_coord(HEIGHT), 1'($urandom),
                   1'($urandom));
   endtask

   // Wait out every owed byte and any clearing pass, then let a tick that yields nothing
   // settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (bus_bytes_q.size() != 0 || req_stall) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Column offset register write; only called with the block idle.
   task automatic write_offset(input logic [OFFSET_W-1:0] value);
      csr_valid         <= 1'b1;
      csr_column_offset <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid  <= 1'b0;
      col_offset = value;
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random stall after each byte, compare against the oldest
   // expectation.
   // ---------------------------------------------------------------------------
   int unsigned stall_left = 0;

   always @(posedge clock) begin
      bus_byte_type got;
      bus_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_out_byte, rsp_transfer_first, rsp_transfer_last, rsp_frame_last,
                rsp_flush_aborted};
         bytes_checked++;
         if (bus_bytes_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0t] unexpected bus byte %02h first=%b last=%b frame_last=%b aborted=%b",
                        $realtime, got.data, got.tx_first, got.tx_last, got.frame_end,
                        got.aborted);
         end else begin
            want = bus_bytes_q.pop_front();
            if (got.data !== want.data || got.tx_first !== want.tx_first ||
                got.tx_last !== want.tx_last || got.frame_end !== want.frame_end ||
                got.aborted !== want.aborted) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("[%0t] bus byte mismatch: expected %02h/%b%b%b%b got %02h/%b%b%b%b",
                           $realtime, want.data, want.tx_first, want.tx_last,
                           want.frame_end, want.aborted, got.data, got.tx_first,
                           got.tx_last, got.frame_end, got.aborted);
            end
         end
         stall_left = quiet ? 0 : $urandom_range(0, 3);
         rsp_stall <= (stall_left != 0);
      end else if (stall_left != 0) begin
         stall_left--;
         if (stall_left == 0) rsp_stall <= 1'b0;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still owed", cycle_count,
                  bus_bytes_q.size());
         $display("page_framebuffer_refresh_unit verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------------

   // Corners of the glass, one past the right and bottom edges, negative and far-out coordinates.
   task automatic test_pixel_bounds();
      send_request(REQ_PIXEL, 9'sd0,    9'sd0,    1'b1, 1'b1);
      send_request(REQ_PIXEL, 9'sd71,   9'sd39,   1'b1, 1'b0);
      send_request(REQ_PIXEL, 9'sd71,   9'sd0,    1'b1, 1'b0);
      send_request(REQ_PIXEL, 9'sd0,    9'sd39,   1'b1, 1'b1);
      send_request(REQ_PIXEL, 9'sd72,   9'sd0,    1'b1, 1'b0);   // right of view
      send_request(REQ_PIXEL, 9'sd0,    9'sd40,   1'b1, 1'b0);   // below view
      send_request(REQ_PIXEL, -9'sd1,   9'sd3,    1'b1, 1'b0);
      send_request(REQ_PIXEL, 9'sd3,    -9'sd256, 1'b1, 1'b1);
      send_request(REQ_PIXEL, 9'sd255,  9'sd255,  1'b1, 1'b0);
      send_request(REQ_PIXEL, 9'sd36,   9'sd20,   1'b1, 1'b0);
      send_request(REQ_PIXEL, 9'sd36,   9'sd20,   1'b0, 1'b1);   // set then clear
   endtask

   // Ticks with no refresh running produce nothing, link failure or not.
   task automatic test_idle_tick();
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   // Refresh at the reset column offset, a second flush while busy, then a link
   // failure mid-stream; the tick after it finds the block idle.
   task automatic test_abort();
      send_request(REQ_FLUSH, 9'sd0, 9'sd0, 1'b0, 1'b0);
      repeat (6) send_tick(1'b0);
      send_request(REQ_FLUSH, -9'sd256, 9'sd255, 1'b1, 1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      drain();
   endtask

   task automatic test_clear();
      send_request(REQ_CLEAR, 9'($urandom), 9'($urandom), 1'b1, 1'b1);
      drain();
   endtask

   // ---------------------------------------------------------------------------
   // Random tests
   // ---------------------------------------------------------------------------

   // One refresh run to completion (or abort), with writes, flushes and, if asked, clears mixed in.
   task automatic run_refresh(input int unsigned abort_odds, input int unsigned clear_odds);
      int unsigned pick;
      send_request(REQ_FLUSH, 9'($urandom), 9'($urandom), 1'($urandom), 1'($urandom));
      while (refreshing) begin
         pick = $urandom_range(0, 999);
         if (pick < abort_odds)
            send_tick(1'b1);
         else if (pick < abort_odds + clear_odds)
            send_request(REQ_CLEAR, 9'($urandom), 9'($urandom), 1'($urandom), 1'($urandom));
         else if (pick < 130)
            paint_pixel();
         else if (pick < 150)
            send_request(REQ_FLUSH, 9'($urandom), 9'($urandom), 1'($urandom),
                         1'($urandom));
         else
            send_tick(1'b0);
      end
   endtask

   // Complete frames at the offset extremes and one random offset.
   task automatic test_refresh_sweep();
      logic [OFFSET_W-1:0] offsets [3];
      offsets = '{7'd0, 7'd127, 7'($urandom)};
      foreach (offsets[i]) begin
         drain();
         write_offset(offsets[i]);
         quiet = (i == 1);
         repeat (40) paint_pixel();
         run_refresh(0, 0);
      end
      quiet = 1'b0;
   endtask

   // Well-formed refreshes (some broken by link failures, some with clears mixed in) and noise.
   task automatic test_random_traffic();
      int unsigned phase;
      phase = 0;
      while (requests_sent < TARGET_REQUESTS) begin
         phase++;
         if (phase % 3 == 0) begin
            drain();
            write_offset(7'($urandom));
         end
         if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(0, 30)) paint_pixel();
            run_refresh(4, 2);
         end else begin
            // noise: every field anything, short abort-prone bursts
            repeat (20)
               send_request(req_kind_type'($urandom_range(0, 3)), 9'($urandom),
                            9'($urandom), 1'($urandom), ($urandom_range(0, 3) == 0));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_pixel_bounds();
      test_idle_tick();
      test_abort();
      test_refresh_sweep();
      test_clear();
      test_random_traffic();
      drain();

      $display("%0d requests (%0d took effect), %0d bus bytes checked", requests_sent,
               requests_acted, bytes_checked);
      $display("%0d complete frames, %0d aborted refreshes, %0d mismatches", frames_done,
               aborts_seen, mismatches);
      if (mismatches == 0)
         $display("page_framebuffer_refresh_unit verification clean");
      else
         $display("page_framebuffer_refresh_unit verification failed");
      $finish;
   end

endmodule

`default_nettype wire
